// File: rtl/core/tfm_pkg.sv
// Package for the topic filter wildcard matcher: constants, codes and the
// structs that pass between the cell chain and the control logic. No dependencies.
package tfm_pkg;

	localparam int unsigned PATTERN_CHARS_DEF = 64;
	localparam int unsigned CHAR_W            = 8;

	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_TOPIC  = 2'd2,
		MODE_END    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		VERDICT_RUN    = 2'd0,
		VERDICT_ACCEPT = 2'd1,
		VERDICT_REJECT = 2'd2
	} verdict_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_STEP = 1'b1
	} state_t;

	// Commands broadcast to every cell of the chain.
	typedef struct packed {
		logic clear;    // drop the whole pattern and put the token on the first cell
		logic append;   // the first empty cell takes the new pattern byte
		logic restart;  // token back to the first cell, pattern kept
		logic advance;  // token moves one cell along
	} chain_cmd_t;

	// What the chain reports about the cell holding the token.
	typedef struct packed {
		logic              at_end;   // token sits at or beyond the pattern length
		logic              is_last;  // token sits on the last stored pattern byte
		logic              full;     // every cell holds a pattern byte
		logic [CHAR_W-1:0] pchar;    // pattern byte under the token
	} chain_stat_t;

endpackage

// File: rtl/core/tfm_in_if.sv
// Input channel of the topic filter matcher: valid/ready handshake with the
// mode and character fields. Depends on tfm_pkg.
interface tfm_in_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                mode;
	logic [tfm_pkg::CHAR_W-1:0] character;

	modport source (output valid, output mode, output character, input ready);
	modport sink   (input valid, input mode, input character, output ready);
endinterface

// File: rtl/core/tfm_out_if.sv
// Result channel of the topic filter matcher: valid/ready handshake with the
// matched and overflow flags. No dependencies.
interface tfm_out_if;
	logic valid;
	logic ready;
	logic matched;
	logic overflow;

	modport source (output valid, output matched, output overflow, input ready);
	modport sink   (input valid, input matched, input overflow, output ready);
endinterface

// File: rtl/core/tfm_cell.sv
// One cell of the pattern chain: holds one pattern byte, its valid bit and the
// matching token. Depends on tfm_pkg.
module tfm_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tfm_pkg::chain_cmd_t         cmd,
	input  logic [tfm_pkg::CHAR_W-1:0]  wr_char,
	input  logic                        head,
	input  logic                        prev_valid,
	input  logic                        prev_token,
	input  logic                        next_valid,
	output logic                        valid,
	output logic                        token,
	output logic                        end_hit,
	output logic                        last_hit,
	output logic [tfm_pkg::CHAR_W-1:0]  sel_char
);

	logic                       valid_q;
	logic                       token_q;
	logic [tfm_pkg::CHAR_W-1:0] char_q;
	logic                       take;

	// Only the first empty cell (the head, or one behind a filled cell) takes an appended byte.
	assign take = cmd.append && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			token_q <= head;
		end else begin
			if (cmd.clear) begin
				valid_q <= 1'b0;
			end else if (take) begin
				valid_q <= 1'b1;
			end
			if (cmd.clear || cmd.restart) begin
				token_q <= head;
			end else if (cmd.advance) begin
				token_q <= prev_token;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_q <= wr_char;
		end
	end

	assign valid    = valid_q;
	assign token    = token_q;
	assign end_hit  = token_q && !valid_q;
	assign last_hit = token_q && valid_q && !next_valid;
	assign sel_char = (token_q && valid_q) ? char_q : '0;

endmodule

// File: rtl/core/tfm_chain.sv
// Row of pattern cells with the token that marks the next pattern byte to match,
// plus the status gathered from the cell that holds it. Depends on tfm_pkg, tfm_cell.
module tfm_chain #(
	parameter int unsigned PATTERN_CHARS = tfm_pkg::PATTERN_CHARS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tfm_pkg::chain_cmd_t         cmd,
	input  logic [tfm_pkg::CHAR_W-1:0]  wr_char,
	output tfm_pkg::chain_stat_t        stat
);

	logic [PATTERN_CHARS-1:0] valid;
	logic [PATTERN_CHARS-1:0] token;
	logic [PATTERN_CHARS-1:0] end_hit;
	logic [PATTERN_CHARS-1:0] last_hit;
	logic [tfm_pkg::CHAR_W-1:0] sel_char [PATTERN_CHARS];
	logic tail_token_q;  // token one place past the last cell

	for (genvar i = 0; i < PATTERN_CHARS; i++) begin : g_cell
		tfm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.wr_char    (wr_char),
			.head       ((i == 0) ? 1'b1 : 1'b0),
			.prev_valid ((i == 0) ? 1'b1 : valid[(i == 0) ? 0 : i-1]),
			.prev_token ((i == 0) ? 1'b0 : token[(i == 0) ? 0 : i-1]),
			.next_valid ((i == PATTERN_CHARS-1) ? 1'b0 :
				valid[(i == PATTERN_CHARS-1) ? i : i+1]),
			.valid      (valid[i]),
			.token      (token[i]),
			.end_hit    (end_hit[i]),
			.last_hit   (last_hit[i]),
			.sel_char   (sel_char[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_token_q <= 1'b0;
		end else if (cmd.clear || cmd.restart) begin
			tail_token_q <= 1'b0;
		end else if (cmd.advance) begin
			tail_token_q <= token[PATTERN_CHARS-1];
		end
	end

	// The token is one-hot, so an OR over the cells selects its byte.
	always_comb begin
		logic [tfm_pkg::CHAR_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < PATTERN_CHARS; i++) begin
			acc = acc | sel_char[i];
		end
		stat.pchar   = acc;
		stat.at_end  = (|end_hit) || tail_token_q;
		stat.is_last = |last_hit;
		stat.full    = valid[PATTERN_CHARS-1];
	end

endmodule

// File: rtl/core/topic_filter_wildcard_match_core.sv
// Top level of the topic filter wildcard matcher: handshake control, the
// per-byte matching step and the result register. Depends on tfm_pkg,
// tfm_in_if, tfm_out_if and tfm_chain.
//
//   Channel  Side    Payload              Per transaction
//   item     sink    mode, character      one command or one topic byte
//   result   source  matched, overflow    one verdict, after each end of topic
//
// Clear, append and end of topic are each acted on in their acceptance cycle.
// A topic byte is matched in its acceptance cycle, and again from a held copy
// for each '+' in the pattern that a '/' (or the start of the byte's match)
// passes over; the token in the cell chain moves at most one cell per cycle.
// Reset empties every cell and puts the token on the first cell at once; no clearing pass.
// A result waits in its register; only an end-of-topic transaction is held off
// while that register is full and not being taken.
module topic_filter_wildcard_match_core #(
	parameter int unsigned PATTERN_CHARS = tfm_pkg::PATTERN_CHARS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	tfm_in_if.sink           item,
	tfm_out_if.source        result
);

	tfm_pkg::state_t            state_q, state_d;
	tfm_pkg::verdict_t          verdict_q;
	logic                       skip_q;
	logic                       ovf_q;
	logic [tfm_pkg::CHAR_W-1:0] char_q;
	logic                       out_valid_q;
	logic                       out_matched_q;
	logic                       out_ovf_q;

	tfm_pkg::chain_cmd_t        cmd;
	tfm_pkg::chain_stat_t       stat;

	logic                       accept;
	logic                       is_clear, is_append, is_topic, is_end;
	logic                       step_en;
	logic [tfm_pkg::CHAR_W-1:0] c_sel;

	// Outcome of one matching step.
	logic                       step_done;
	logic                       step_advance;
	logic                       step_skip;
	logic                       step_set_verdict;
	tfm_pkg::verdict_t          step_verdict;
	logic                       finish;

	tfm_chain #(
		.PATTERN_CHARS (PATTERN_CHARS)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.wr_char (item.character),
		.stat    (stat)
	);

	assign is_clear  = (item.mode == tfm_pkg::MODE_CLEAR);
	assign is_append = (item.mode == tfm_pkg::MODE_APPEND);
	assign is_topic  = (item.mode == tfm_pkg::MODE_TOPIC);
	assign is_end    = (item.mode == tfm_pkg::MODE_END);

	// New transactions are taken only between topic bytes; an end of topic
	// also needs room in the result register.
	assign item.ready = (state_q == tfm_pkg::S_IDLE) &&
		!(is_end && out_valid_q && !result.ready);
	assign accept = item.valid && item.ready;

	// The first step of a topic byte runs in its acceptance cycle, later steps
	// from the held copy of the byte.
	assign step_en = (accept && is_topic && (verdict_q == tfm_pkg::VERDICT_RUN)) ||
		(state_q == tfm_pkg::S_STEP);
	assign c_sel   = (state_q == tfm_pkg::S_STEP) ? char_q : item.character;

	// One step of matching a topic byte against the pattern byte under the token.
	always_comb begin
		step_done        = 1'b1;
		step_advance     = 1'b0;
		step_skip        = 1'b0;
		step_set_verdict = 1'b0;
		step_verdict     = tfm_pkg::VERDICT_RUN;
		if (skip_q && (c_sel != tfm_pkg::CH_SLASH)) begin
			// A '+' swallows this byte.
			step_skip = 1'b1;
		end else if (stat.at_end) begin
			// The topic runs longer than the pattern.
			step_set_verdict = 1'b1;
			step_verdict     = tfm_pkg::VERDICT_REJECT;
		end else if (stat.pchar == tfm_pkg::CH_PLUS) begin
			step_advance = 1'b1;
			step_skip    = 1'b1;
			step_done    = 1'b0;
		end else if (stat.pchar == tfm_pkg::CH_HASH) begin
			step_set_verdict = 1'b1;
			step_verdict     = stat.is_last ? tfm_pkg::VERDICT_ACCEPT :
				tfm_pkg::VERDICT_REJECT;
		end else if (stat.pchar == c_sel) begin
			step_advance = 1'b1;
		end else begin
			step_set_verdict = 1'b1;
			step_verdict     = tfm_pkg::VERDICT_REJECT;
		end
	end

	// Verdict at the end of a topic, from the state that matching has left.
	always_comb begin
		if (verdict_q == tfm_pkg::VERDICT_ACCEPT) begin
			finish = 1'b1;
		end else if (verdict_q == tfm_pkg::VERDICT_REJECT) begin
			finish = 1'b0;
		end else if (stat.at_end) begin
			finish = 1'b1;
		end else if (skip_q) begin
			finish = 1'b0;
		end else if ((stat.pchar == tfm_pkg::CH_PLUS) || (stat.pchar == tfm_pkg::CH_HASH)) begin
			finish = stat.is_last;
		end else begin
			finish = 1'b0;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tfm_pkg::S_IDLE: begin
				if (step_en && !step_done) begin
					state_d = tfm_pkg::S_STEP;
				end
			end
			tfm_pkg::S_STEP: begin
				if (step_done) begin
					state_d = tfm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tfm_pkg::S_IDLE;
			end
		endcase
	end

	// Commands to the cell chain.
	always_comb begin
		cmd.clear   = accept && is_clear;
		cmd.append  = accept && is_append && !stat.full;
		cmd.restart = accept && is_end;
		cmd.advance = step_en && step_advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tfm_pkg::S_IDLE;
			verdict_q <= tfm_pkg::VERDICT_RUN;
			skip_q    <= 1'b0;
			ovf_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (is_clear || is_end)) begin
				verdict_q <= tfm_pkg::VERDICT_RUN;
				skip_q    <= 1'b0;
			end else if (step_en) begin
				skip_q <= step_skip;
				if (step_set_verdict) begin
					verdict_q <= step_verdict;
				end
			end
			if (accept && is_clear) begin
				ovf_q <= 1'b0;
			end else if (accept && is_append && stat.full) begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_topic) begin
			char_q <= item.character;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && is_end) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_end) begin
			out_matched_q <= finish && !ovf_q;
			out_ovf_q     <= ovf_q;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.matched  = out_matched_q;
	assign result.overflow = out_ovf_q;

endmodule

// File: bench/tb_topic_filter_wildcard_match_core.sv
`timescale 1ns / 100ps
// Self-checking bench for topic_filter_wildcard_match_core: random filters and topics
// against a cycle-free predictor of the matcher. Depends on tfm_pkg, tfm_in_if, tfm_out_if and the core.
module tb_topic_filter_wildcard_match_core;

	localparam int unsigned FILTER_CAP   = 64;     // pattern capacity of the instance
	localparam int unsigned LONG_HOLD    = 400;    // cycles the result side refuses in a row
	localparam int unsigned PHASE_ITEMS  = 270;    // random transactions per idling phase
	localparam int unsigned SETTLE_TICKS = 100;    // a topic byte may walk the whole chain

	// One input transaction and one expected verdict.
	typedef struct {
		tfm_pkg::mode_t mode;
		logic [7:0]     character;
	} topic_cmd_t;

	typedef struct {
		logic matched;
		logic overflow;
	} verdict_rec_t;

	logic clk;
	logic arst_n;

	tfm_in_if  item_ch ();
	tfm_out_if result_ch ();

	topic_filter_wildcard_match_core #(
		.PATTERN_CHARS(FILTER_CAP)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch)
	);

	always #5 clk = ~clk;

	// Stimulus and scoreboard state.
	topic_cmd_t   cmd_queue[$];
	verdict_rec_t verdicts_due[$];
	logic [7:0]   filt_q[$];
	logic [7:0]   topic_q[$];
	int unsigned  cmds_pushed;
	int unsigned  cmds_taken;
	int unsigned  mismatches;
	int unsigned  send_idle_pct;
	int unsigned  recv_idle_pct;
	int unsigned  hold_reqs;
	int unsigned  hold_done;
	int unsigned  hold_left;
	logic         drv_busy;
	topic_cmd_t   drv_next;
	verdict_rec_t due_now;

	// Predictor state: a private copy of the pattern store and the matching registers.
	logic [7:0]        pat_mem[FILTER_CAP];
	int unsigned       pat_len;
	int unsigned       pat_pos;
	logic              skipping;
	tfm_pkg::verdict_t match_state;
	logic              pat_ovf;

	// One topic byte against the pattern. A '+' is stepped over straight away and then
	// swallows bytes until a '/', which is handed back to the next pattern byte; so a
	// run of adjacent '+' bytes can be passed by a single '/' in several steps.
	function void topic_advance(input logic [7:0] c);
		logic [7:0]  pc;
		int unsigned guard;
		if (match_state != tfm_pkg::VERDICT_RUN)
			return;
		for (guard = 0; guard < FILTER_CAP + 2; guard++) begin
			if (skipping) begin
				if (c != tfm_pkg::CH_SLASH)
					return;
				skipping = 1'b0;
			end
			if (pat_pos >= pat_len) begin
				match_state = tfm_pkg::VERDICT_REJECT;
				return;
			end
			pc = pat_mem[pat_pos];
			if (pc == tfm_pkg::CH_PLUS) begin
				pat_pos++;
				skipping = 1'b1;
			end else if (pc == tfm_pkg::CH_HASH) begin
				match_state = (pat_pos + 1 == pat_len) ? tfm_pkg::VERDICT_ACCEPT :
					tfm_pkg::VERDICT_REJECT;
				return;
			end else begin
				if (pc == c)
					pat_pos++;
				else
					match_state = tfm_pkg::VERDICT_REJECT;
				return;
			end
		end
		match_state = tfm_pkg::VERDICT_REJECT;
	endfunction

	// Decision at end of topic. A trailing '+' or '#' may stand for nothing, but only if
	// it is the last pattern byte; a level that '+' is still swallowing with pattern
	// left over is a miss. This is also why "a/#" does not match the bare "a".
	function logic topic_verdict();
		logic [7:0] pc;
		if (match_state == tfm_pkg::VERDICT_ACCEPT)
			return 1'b1;
		if (match_state == tfm_pkg::VERDICT_REJECT)
			return 1'b0;
		if (pat_pos >= pat_len)
			return 1'b1;
		if (skipping)
			return 1'b0;
		pc = pat_mem[pat_pos];
		if (pc == tfm_pkg::CH_PLUS || pc == tfm_pkg::CH_HASH)
			return pat_pos + 1 == pat_len;
		return 1'b0;
	endfunction

	// Applies one accepted transaction to the predictor and queues the verdict it owes.
	function void filter_apply(input tfm_pkg::mode_t m, input logic [7:0] c);
		verdict_rec_t rec;
		case (m)
			tfm_pkg::MODE_CLEAR: begin
				pat_len     = 0;
				pat_ovf     = 1'b0;
				pat_pos     = 0;
				skipping    = 1'b0;
				match_state = tfm_pkg::VERDICT_RUN;
			end
			tfm_pkg::MODE_APPEND: begin
				// A full store drops the byte and remembers that it did.
				if (pat_len < FILTER_CAP) begin
					pat_mem[pat_len] = c;
					pat_len++;
				end else begin
					pat_ovf = 1'b1;
				end
			end
			tfm_pkg::MODE_TOPIC: begin
				topic_advance(c);
			end
			default: begin
				rec.matched  = topic_verdict() && !pat_ovf;
				rec.overflow = pat_ovf;
				verdicts_due.push_back(rec);
				pat_pos     = 0;
				skipping    = 1'b0;
				match_state = tfm_pkg::VERDICT_RUN;
			end
		endcase
	endfunction

	// Driver: holds a transaction until it is taken, then offers the next one or idles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid     <= 1'b0;
			item_ch.mode      <= tfm_pkg::MODE_CLEAR;
			item_ch.character <= '0;
		end else begin
			drv_busy = item_ch.valid;
			if (item_ch.valid && item_ch.ready) begin
				filter_apply(tfm_pkg::mode_t'(item_ch.mode), item_ch.character);
				cmds_taken++;
				drv_busy = 1'b0;
			end
			if (!drv_busy) begin
				if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_next = cmd_queue.pop_front();
					item_ch.valid     <= 1'b1;
					item_ch.mode      <= drv_next.mode;
					item_ch.character <= drv_next.character;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every verdict taken against the oldest expectation and decides
	// ready for the next cycle. A long hold, once asked for, is counted down here.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (verdicts_due.size() == 0) begin
					$error("unexpected verdict: matched=%0b overflow=%0b",
						result_ch.matched, result_ch.overflow);
					mismatches++;
				end else begin
					due_now = verdicts_due.pop_front();
					if (result_ch.matched !== due_now.matched) begin
						$error("matched: expected %0b, got %0b",
							due_now.matched, result_ch.matched);
						mismatches++;
					end
					if (result_ch.overflow !== due_now.overflow) begin
						$error("overflow: expected %0b, got %0b",
							due_now.overflow, result_ch.overflow);
						mismatches++;
					end
				end
			end
			if (hold_reqs != hold_done) begin
				hold_done = hold_reqs;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task push_cmd(input tfm_pkg::mode_t m, input logic [7:0] c);
		topic_cmd_t t;
		t.mode      = m;
		t.character = c;
		cmd_queue.push_back(t);
		cmds_pushed++;
	endtask

	// Mostly letters and separators, with the odd arbitrary byte.
	function logic [7:0] rand_letter();
		int unsigned r;
		r = $urandom_range(15);
		if (r == 0)
			return 8'($urandom_range(255));
		if (r <= 6)
			return "a";
		if (r <= 10)
			return "b";
		if (r <= 13)
			return tfm_pkg::CH_SLASH;
		if (r == 14)
			return tfm_pkg::CH_PLUS;
		return tfm_pkg::CH_HASH;
	endfunction

	// Random filter of a few levels; now and then a run of '+', '/' and 'a' bytes whose
	// length lies between FILTER_CAP - 4 and FILTER_CAP + 6, for long chain walks and overflow.
	task build_filter();
		int unsigned levels, k, j, n, r;
		filt_q.delete();
		if ($urandom_range(19) == 0) begin
			n = $urandom_range(FILTER_CAP + 6, FILTER_CAP - 4);
			for (j = 0; j < n; j++) begin
				r = $urandom_range(2);
				filt_q.push_back(r == 0 ? tfm_pkg::CH_PLUS :
					(r == 1 ? tfm_pkg::CH_SLASH : 8'h61));
			end
		end else begin
			levels = $urandom_range(4);
			for (k = 0; k < levels; k++) begin
				if (k > 0)
					filt_q.push_back(tfm_pkg::CH_SLASH);
				r = $urandom_range(9);
				if (r < 2) begin
					filt_q.push_back(tfm_pkg::CH_PLUS);
				end else if (r == 2 && k == levels - 1) begin
					filt_q.push_back(tfm_pkg::CH_HASH);
				end else if (r == 3 && $urandom_range(3) == 0) begin
					filt_q.push_back(tfm_pkg::CH_HASH);  // '#' that lands mid pattern never matches past it
				end else begin
					n = $urandom_range(3);
					for (j = 0; j < n; j++)
						filt_q.push_back(rand_letter());
				end
			end
		end
	endtask

	// Topic mostly derived from the current filter so that matches are common; some
	// are mutated by one byte and some are plain noise.
	task build_topic();
		int unsigned j, n, w;
		logic [7:0]  c;
		topic_q.delete();
		if ($urandom_range(3) == 0) begin
			n = $urandom_range(8);
			for (j = 0; j < n; j++)
				topic_q.push_back(rand_letter());
		end else begin
			for (j = 0; j < filt_q.size(); j++) begin
				c = filt_q[j];
				if (c == tfm_pkg::CH_PLUS) begin
					n = $urandom_range(3);
					for (w = 0; w < n; w++)
						topic_q.push_back(8'h61 + 8'($urandom_range(2)));
				end else if (c == tfm_pkg::CH_HASH) begin
					// Sometimes the bare parent, which the trailing "/#" must refuse.
					if (topic_q.size() != 0 && topic_q[$] == tfm_pkg::CH_SLASH &&
						$urandom_range(1))
						void'(topic_q.pop_back());
					else begin
						n = $urandom_range(4);
						for (w = 0; w < n; w++)
							topic_q.push_back(rand_letter());
					end
					break;
				end else begin
					topic_q.push_back(c);
				end
			end
			if (topic_q.size() != 0 && $urandom_range(4) == 0)
				topic_q[$urandom_range(topic_q.size() - 1)] = rand_letter();
		end
	endtask

	// Queues the topic and its end; once in a while a pattern byte is appended at a random point.
	task queue_topic();
		int unsigned j, cut;
		cut = ($urandom_range(9) == 0) ? $urandom_range(topic_q.size()) : topic_q.size() + 1;
		for (j = 0; j <= topic_q.size(); j++) begin
			if (j == cut)
				push_cmd(tfm_pkg::MODE_APPEND, rand_letter());
			if (j < topic_q.size())
				push_cmd(tfm_pkg::MODE_TOPIC, topic_q[j]);
		end
		push_cmd(tfm_pkg::MODE_END, '0);
	endtask

	task queue_random(input int unsigned count);
		int unsigned first, j, n;
		first = cmds_pushed;
		while (cmds_pushed - first < count) begin
			if ($urandom_range(9) == 0) begin
				// Noise: any mode with any byte, clears included.
				n = $urandom_range(6, 1);
				for (j = 0; j < n; j++)
					push_cmd(tfm_pkg::mode_t'($urandom_range(3)), 8'($urandom_range(255)));
			end else begin
				build_filter();
				push_cmd(tfm_pkg::MODE_CLEAR, 8'($urandom_range(255)));
				for (j = 0; j < filt_q.size(); j++)
					push_cmd(tfm_pkg::MODE_APPEND, filt_q[j]);
				n = $urandom_range(4, 1);
				for (j = 0; j < n; j++) begin
					build_topic();
					queue_topic();
				end
			end
		end
	endtask

	// Sender pause: nothing more is offered until every transaction has been taken and
	// every verdict owed has come back.
	task wait_drained();
		while (cmds_taken != cmds_pushed || verdicts_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		item_ch.valid        = 1'b0;
		item_ch.mode         = tfm_pkg::MODE_CLEAR;
		item_ch.character    = '0;
		result_ch.ready      = 1'b0;
		cmds_pushed          = 0;
		cmds_taken           = 0;
		mismatches           = 0;
		hold_reqs            = 0;
		hold_done            = 0;
		pat_len              = 0;
		pat_pos              = 0;
		skipping             = 1'b0;
		match_state          = tfm_pkg::VERDICT_RUN;
		pat_ovf              = 1'b0;
		send_idle_pct        = 6;
		recv_idle_pct        = 62;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opening. Empty pattern against the empty topic matches.
		push_cmd(tfm_pkg::MODE_END, '0);
		// Empty pattern against a one-byte topic (a zero byte) does not.
		push_cmd(tfm_pkg::MODE_TOPIC, 8'h00);
		push_cmd(tfm_pkg::MODE_END, 8'hFF);
		// "a/#": the bare parent is refused, a child level with an all-ones byte accepted.
		push_cmd(tfm_pkg::MODE_APPEND, "a");
		push_cmd(tfm_pkg::MODE_APPEND, tfm_pkg::CH_SLASH);
		push_cmd(tfm_pkg::MODE_APPEND, tfm_pkg::CH_HASH);
		push_cmd(tfm_pkg::MODE_TOPIC, "a");
		push_cmd(tfm_pkg::MODE_END, '0);
		push_cmd(tfm_pkg::MODE_TOPIC, "a");
		push_cmd(tfm_pkg::MODE_TOPIC, tfm_pkg::CH_SLASH);
		push_cmd(tfm_pkg::MODE_TOPIC, 8'hFF);
		push_cmd(tfm_pkg::MODE_END, '0);
		// A clear with a byte that must be ignored, then a lone '+' matching nothing.
		push_cmd(tfm_pkg::MODE_CLEAR, 8'hFF);
		push_cmd(tfm_pkg::MODE_APPEND, tfm_pkg::CH_PLUS);
		push_cmd(tfm_pkg::MODE_END, '0);
		// Pattern grows while the topic is running; the zero byte is an ordinary byte.
		push_cmd(tfm_pkg::MODE_TOPIC, "x");
		push_cmd(tfm_pkg::MODE_APPEND, tfm_pkg::CH_SLASH);
		push_cmd(tfm_pkg::MODE_APPEND, 8'h00);
		push_cmd(tfm_pkg::MODE_TOPIC, tfm_pkg::CH_SLASH);
		push_cmd(tfm_pkg::MODE_TOPIC, 8'h00);
		push_cmd(tfm_pkg::MODE_END, '0);
		// The leading '+' swallows both bytes, a '+' byte included, and is still in its
		// level at the end with pattern left over, so this is a miss.
		push_cmd(tfm_pkg::MODE_TOPIC, "q");
		push_cmd(tfm_pkg::MODE_TOPIC, tfm_pkg::CH_PLUS);
		push_cmd(tfm_pkg::MODE_END, '0);

		// First phase: the result side is the slow one, and for a long stretch it takes
		// nothing at all, so the result register fills and ends of topic back up.
		queue_random(PHASE_ITEMS);
		hold_reqs++;
		wait_drained();

		send_idle_pct = 62;
		recv_idle_pct = 6;
		queue_random(PHASE_ITEMS);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(PHASE_ITEMS);
		wait_drained();

		repeat (SETTLE_TICKS) @(posedge clk);
		if (mismatches == 0 && verdicts_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/tfm_pkg.sv
rtl/core/tfm_in_if.sv
rtl/core/tfm_out_if.sv
rtl/core/tfm_cell.sv
rtl/core/tfm_chain.sv
rtl/core/topic_filter_wildcard_match_core.sv
bench/tb_topic_filter_wildcard_match_core.sv
